// ----- src/tpam_pkg.sv -----
// ----------------------------------------------------------------------------
// tpam_pkg
// Shared types and constants for the tile order pixel address mapper.
// ----------------------------------------------------------------------------
package tpam_pkg;

    // Address arithmetic wraps at ADDR_BITS; the output carries the low bits.
    localparam int ADDR_BITS = 20;
    localparam int ADDR_W    = 20;
    localparam int MASK_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << MASK_BITS) - 64'd1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_META_ACROSS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_META_WIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_META_HIGH   = 3'd4;
    localparam int CFG_DATA_W = 8;

    // Pixel depth codes.
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;

    // Configuration register contents.
    typedef struct packed {
        logic [1:0] depth_mode;
        logic       invert_pixels;
        logic [7:0] metatiles_across;
        logic [5:0] metatile_tiles_wide;
        logic [5:0] metatile_tiles_high;
    } t_cfg;

    // Controller state.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_MUL,
        ST_SUM
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic calc_row;
        logic calc_mul;
        logic load_out;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_blocked;
    } t_ctrl_status;

endpackage

// ----- src/tile_order_pixel_address_mapper.sv -----
// ----------------------------------------------------------------------------
// tile_order_pixel_address_mapper
// Maps bytes given in tile and metatile order to linear bitmap addresses and
// transforms the pixel data for the configured depth.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An accepted byte passes these steps
// until its result sits in the output register: the metatile products, then
// the pixel row, byte column and pitch, then the row-times-pitch
// multiplication and last the final add. A new byte is taken only after
// the previous one has been loaded into the output register, and a result
// waiting in the output register lets the next byte enter and run up to
// its final add. The user must see that configuration is written only
// while no transaction is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tile_order_pixel_address_mapper (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [tpam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_pixel_byte,
    input  logic                           i_restart,
    // Output channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tpam_pkg::ADDR_W-1:0]     o_linear_address,
    output logic [7:0]                     o_pixel_out,
    output logic                           o_tile_end
);

    tpam_pkg::t_cfg         cfg;
    tpam_pkg::t_ctrl_cmd    cmd;
    tpam_pkg::t_ctrl_status status;

    // Configuration registers.
    tpam_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Transaction sequencer.
    tpam_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    // Counters, arithmetic and output register.
    tpam_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_pixel_byte     (i_pixel_byte),
        .i_restart        (i_restart),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_linear_address (o_linear_address),
        .o_pixel_out      (o_pixel_out),
        .o_tile_end       (o_tile_end)
    );

endmodule

// ----- src/tpam_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tpam_cfg_regs
// Configuration register file written through a simple write port.
// ----------------------------------------------------------------------------
module tpam_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpam_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tpam_pkg::t_cfg                  o_cfg
);

    tpam_pkg::t_cfg r_cfg;
    tpam_pkg::t_cfg n_cfg;

    // Decode the register index; writes to unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                tpam_pkg::CFG_DEPTH_MODE:  n_cfg.depth_mode          = i_cfg_data[1:0];
                tpam_pkg::CFG_INVERT:      n_cfg.invert_pixels       = i_cfg_data[0];
                tpam_pkg::CFG_META_ACROSS: n_cfg.metatiles_across    = i_cfg_data[7:0];
                tpam_pkg::CFG_META_WIDE:   n_cfg.metatile_tiles_wide = i_cfg_data[5:0];
                tpam_pkg::CFG_META_HIGH:   n_cfg.metatile_tiles_high = i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_mode          <= tpam_pkg::DEPTH_4BPP;
            r_cfg.invert_pixels       <= 1'b0;
            r_cfg.metatiles_across    <= 8'd1;
            r_cfg.metatile_tiles_wide <= 6'd1;
            r_cfg.metatile_tiles_high <= 6'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/tpam_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpam_ctrl
// Sequencer that steps one transaction through the address datapath.
// ----------------------------------------------------------------------------
module tpam_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  tpam_pkg::t_ctrl_status i_status,
    output tpam_pkg::t_ctrl_cmd    o_cmd,
    output logic                   o_stall
);

    tpam_pkg::t_state r_state;
    tpam_pkg::t_state n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tpam_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = tpam_pkg::ST_ROW;
                end
            end
            tpam_pkg::ST_ROW: n_state = tpam_pkg::ST_MUL;
            tpam_pkg::ST_MUL: n_state = tpam_pkg::ST_SUM;
            tpam_pkg::ST_SUM: begin
                if (!i_status.out_blocked) begin
                    n_state = tpam_pkg::ST_IDLE;
                end
            end
            default: n_state = tpam_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            tpam_pkg::ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            tpam_pkg::ST_ROW: o_cmd.calc_row = 1'b1;
            tpam_pkg::ST_MUL: o_cmd.calc_mul = 1'b1;
            tpam_pkg::ST_SUM: o_cmd.load_out = !i_status.out_blocked;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpam_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/tpam_datapath.sv -----
// ----------------------------------------------------------------------------
// tpam_datapath
// Tile position counters, address arithmetic, pixel transform and the
// output register.
// ----------------------------------------------------------------------------
module tpam_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tpam_pkg::t_cfg                    i_cfg,
    input  tpam_pkg::t_ctrl_cmd               i_cmd,
    output tpam_pkg::t_ctrl_status            o_status,
    input  logic [7:0]                        i_pixel_byte,
    input  logic                              i_restart,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [tpam_pkg::ADDR_W-1:0]       o_linear_address,
    output logic [7:0]                        o_pixel_out,
    output logic                              o_tile_end
);

    // Metatile sizes of zero act as one, and sizes above 32 act as 32.
    function automatic logic [5:0] clamp_tiles(input logic [5:0] v);
        logic [5:0] r;
        if (v == 6'd0) begin
            r = 6'd1;
        end else if (v > 6'd32) begin
            r = 6'd32;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Effective configuration.
    logic [5:0] w;
    logic [5:0] h;
    logic [7:0] a;
    logic [1:0] bpr_shift;
    logic [2:0] bpr_last;

    assign w = clamp_tiles(i_cfg.metatile_tiles_wide);
    assign h = clamp_tiles(i_cfg.metatile_tiles_high);
    assign a = (i_cfg.metatiles_across == 8'd0) ? 8'd1 : i_cfg.metatiles_across;

    // Bytes per tile row as a shift amount, and the index of its last byte.
    always_comb begin
        case (i_cfg.depth_mode)
            tpam_pkg::DEPTH_1BPP: begin
                bpr_shift = 2'd0;
                bpr_last  = 3'd0;
            end
            tpam_pkg::DEPTH_4BPP: begin
                bpr_shift = 2'd2;
                bpr_last  = 3'd3;
            end
            default: begin
                bpr_shift = 2'd3;
                bpr_last  = 3'd7;
            end
        endcase
    end

    // Position counters.
    logic [2:0]  r_bir, n_bir;
    logic [2:0]  r_rit, n_rit;
    logic [4:0]  r_stc, n_stc;
    logic [4:0]  r_str, n_str;
    logic [7:0]  r_mc,  n_mc;
    logic [15:0] r_mr,  n_mr;

    // Position that applies to the current transaction, after restart.
    logic [2:0]  e_bir;
    logic [2:0]  e_rit;
    logic [4:0]  e_stc;
    logic [4:0]  e_str;
    logic [7:0]  e_mc;
    logic [15:0] e_mr;
    logic        row_done;
    logic        tile_done;

    assign e_bir = i_restart ? 3'd0  : r_bir;
    assign e_rit = i_restart ? 3'd0  : r_rit;
    assign e_stc = i_restart ? 5'd0  : r_stc;
    assign e_str = i_restart ? 5'd0  : r_str;
    assign e_mc  = i_restart ? 8'd0  : r_mc;
    assign e_mr  = i_restart ? 16'd0 : r_mr;

    // A tile row also ends when a depth change left the byte count past its end.
    assign row_done  = (e_bir >= bpr_last);
    assign tile_done = row_done && (e_rit == 3'd7);

    // Advance through bytes, rows, tiles within the metatile, then metatiles.
    always_comb begin
        n_bir = e_bir;
        n_rit = e_rit;
        n_stc = e_stc;
        n_str = e_str;
        n_mc  = e_mc;
        n_mr  = e_mr;
        if (!row_done) begin
            n_bir = e_bir + 3'd1;
        end else begin
            n_bir = 3'd0;
            if (e_rit != 3'd7) begin
                n_rit = e_rit + 3'd1;
            end else begin
                n_rit = 3'd0;
                if (({1'b0, e_stc} + 6'd1) < w) begin
                    n_stc = e_stc + 5'd1;
                end else begin
                    n_stc = 5'd0;
                    if (({1'b0, e_str} + 6'd1) < h) begin
                        n_str = e_str + 5'd1;
                    end else begin
                        n_str = 5'd0;
                        if (({1'b0, e_mc} + 9'd1) < {1'b0, a}) begin
                            n_mc = e_mc + 8'd1;
                        end else begin
                            n_mc = 8'd0;
                            n_mr = e_mr + 16'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bir <= '0;
            r_rit <= '0;
            r_stc <= '0;
            r_str <= '0;
            r_mc  <= '0;
            r_mr  <= '0;
        end else if (i_cmd.accept) begin
            r_bir <= n_bir;
            r_rit <= n_rit;
            r_stc <= n_stc;
            r_str <= n_str;
            r_mc  <= n_mc;
            r_mr  <= n_mr;
        end
    end

    // Pixel transform: bit reverse, nibble swap or pass, then optional invert.
    logic [7:0] rev_byte;
    logic [7:0] px;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            rev_byte[i] = i_pixel_byte[7-i];
        end
    end

    always_comb begin
        case (i_cfg.depth_mode)
            tpam_pkg::DEPTH_1BPP: px = rev_byte;
            tpam_pkg::DEPTH_4BPP: px = {i_pixel_byte[3:0], i_pixel_byte[7:4]};
            default:              px = i_pixel_byte;
        endcase
        if (i_cfg.invert_pixels) begin
            px = ~px;
        end
    end

    // First step: metatile products, taken when the transaction is accepted.
    logic [21:0] mrh;
    logic [13:0] mcw;
    logic [13:0] aw;

    assign mrh = {6'd0, e_mr} * {16'd0, h};
    assign mcw = {6'd0, e_mc} * {8'd0, w};
    assign aw  = {6'd0, a} * {8'd0, w};

    logic [21:0] r_mrh;
    logic [13:0] r_mcw;
    logic [13:0] r_aw;
    logic [4:0]  r_p_str;
    logic [4:0]  r_p_stc;
    logic [2:0]  r_p_rit;
    logic [2:0]  r_p_bir;
    logic [7:0]  r_px;
    logic        r_tile_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mrh       <= mrh;
            r_mcw       <= mcw;
            r_aw        <= aw;
            r_p_str     <= e_str;
            r_p_stc     <= e_stc;
            r_p_rit     <= e_rit;
            r_p_bir     <= e_bir;
            r_px        <= px;
            r_tile_done <= tile_done;
        end
    end

    // Second step: pixel row, byte column and pitch. Only the low address
    // bits of the row are kept, since everything downstream wraps.
    logic [21:0] row_base;
    logic [24:0] row_full;
    logic [13:0] col_base;
    logic [16:0] col_full;
    logic [16:0] pitch;

    assign row_base = r_mrh + {17'd0, r_p_str};
    assign row_full = {row_base, 3'b000} + {22'd0, r_p_rit};
    assign col_base = r_mcw + {9'd0, r_p_stc};
    assign col_full = ({3'd0, col_base} << bpr_shift) + {14'd0, r_p_bir};
    assign pitch    = {3'd0, r_aw} << bpr_shift;

    logic [tpam_pkg::ADDR_W-1:0] r_row;
    logic [16:0]                 r_col;
    logic [16:0]                 r_pitch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_row) begin
            r_row   <= row_full[tpam_pkg::ADDR_W-1:0];
            r_col   <= col_full;
            r_pitch <= pitch;
        end
    end

    // Third step: row times pitch.
    logic [tpam_pkg::ADDR_W+16:0] prod_full;
    logic [tpam_pkg::ADDR_W-1:0]  r_prod;

    assign prod_full = {17'd0, r_row} * {{tpam_pkg::ADDR_W{1'b0}}, r_pitch};

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_mul) begin
            r_prod <= prod_full[tpam_pkg::ADDR_W-1:0];
        end
    end

    // Final step: add the column and wrap into the output register.
    logic [tpam_pkg::ADDR_W-1:0] addr_sum;

    assign addr_sum = r_prod + {{(tpam_pkg::ADDR_W-17){1'b0}}, r_col};

    logic                        r_out_valid;
    logic [tpam_pkg::ADDR_W-1:0] r_out_addr;
    logic [7:0]                  r_out_px;
    logic                        r_out_tile_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_addr     <= addr_sum & tpam_pkg::ADDR_MASK;
            r_out_px       <= r_px;
            r_out_tile_end <= r_tile_done;
        end
    end

    assign o_status.out_blocked = r_out_valid && i_stall;

    assign o_valid          = r_out_valid;
    assign o_linear_address = r_out_addr;
    assign o_pixel_out      = r_out_px;
    assign o_tile_end       = r_out_tile_end;

endmodule
